@@ hw/rtl/pwrp_pkg.sv @@
// ============================================================================
// pwrp_pkg: shared types and constants
// Types and sizes for the priority weighted random picker.
// ============================================================================
package pwrp_pkg;

    localparam int ENTRIES     = 32;
    localparam int KEY_BITS    = 16;
    localparam int SOURCE_BITS = 16;
    localparam int IDX_BITS    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_BITS    = $clog2(ENTRIES + 1);
    localparam int SUM_BITS    = 15 + CNT_BITS;
    localparam int MAX_OUT     = 32;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_BROKEN = 2'd1,
        ACT_PICK   = 2'd2,
        ACT_LIST   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_NONE  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN1,
        S_MUL,
        S_SCAN2,
        S_LIST,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [15:0]        key_id;
        logic [15:0]        source_id;
        logic signed [7:0]  priority_req;
        logic signed [15:0] weight;
        logic [15:0]        random_fraction;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [4:0]         entry_index;
        logic [15:0]        chosen_source;
        logic signed [7:0]  chosen_priority;
        logic signed [15:0] chosen_weight;
        logic               last;
    } rsp_t;

    // one table row as read out by the scan
    typedef struct packed {
        logic [KEY_BITS-1:0]    key;
        logic [SOURCE_BITS-1:0] src;
        logic signed [7:0]      prio;
        logic signed [15:0]     wt;
        logic                   broken;
    } row_t;

endpackage

@@ hw/rtl/pwrp_table.sv @@
// ============================================================================
// pwrp_table: entry store
// One write port and one registered read port over the entry fields.
// ============================================================================
module pwrp_table (
    input  logic                        clk,
    input  logic                        we,
    input  logic [pwrp_pkg::IDX_BITS-1:0] waddr,
    input  pwrp_pkg::row_t              wdata,
    input  logic [pwrp_pkg::IDX_BITS-1:0] raddr,
    output pwrp_pkg::row_t              rdata
);
    import pwrp_pkg::*;

    row_t mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/priority_weighted_random_picker_core.sv @@
// ============================================================================
// priority_weighted_random_picker_core: weighted source selection
// Appends entries, marks broken ones, picks by weight, lists per key.
// ============================================================================
// Add goes straight from idle to the emit state; report broken and list scan
// the n stored entries one slot per cycle through the single registered read
// port; pick makes two passes with a multiply step between them, and the
// second pass stops after the chosen slot. busy stays high for the whole item;
// the next item can be taken in the cycle after the final beat. Results leave
// as one-cycle strobed beats; list emits one beat per match, or one none beat
// if nothing matches. Reset clears the fill count and the sequencer; table
// contents stay unset.
module priority_weighted_random_picker_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  pwrp_pkg::req_t  req,
    output logic            busy,
    output logic            done,
    output pwrp_pkg::rsp_t  rsp
);
    import pwrp_pkg::*;

    state_t state_reg, state_next;
    req_t   req_reg;
    logic [CNT_BITS-1:0] count_reg;
    // scan address, one beyond the last slot when the pass ends
    logic [CNT_BITS-1:0] addr_reg, addr_next;
    // address of the row now on rdata, and its valid flag
    logic [CNT_BITS-1:0] raddr_d_reg;
    logic                rvalid_reg;

    logic                found_reg;
    logic signed [7:0]   top_reg;
    logic [IDX_BITS-1:0] first_reg;
    logic [SUM_BITS-1:0] sum_reg, psum_reg;
    logic [SUM_BITS+15:0] target_reg;
    logic                hit_reg;
    logic [5:0]          nout_reg;
    rsp_t                rsp_reg;
    logic                done_reg;
    // list holds one matching row back so the last one can carry the mark
    rsp_t                hold_reg;
    logic                hold_v_reg;

    logic   we;
    row_t   wrow, rrow;
    logic [IDX_BITS-1:0] raddr;

    assign raddr = addr_reg[IDX_BITS-1:0];

    pwrp_table u_table (
        .clk   (clk),
        .we    (we),
        .waddr (we ? (state_reg == S_IDLE ? count_reg[IDX_BITS-1:0]
                                          : raddr_d_reg[IDX_BITS-1:0])
                   : count_reg[IDX_BITS-1:0]),
        .wdata (wrow),
        .raddr (raddr),
        .rdata (rrow)
    );

    logic add_now, add_ok, scanning, last_row, row_key, row_match;

    assign add_now  = start && !busy && (action_t'(req.action) == ACT_ADD);
    assign add_ok   = add_now && (count_reg < CNT_BITS'(ENTRIES));
    assign scanning = (state_reg == S_SCAN1) || (state_reg == S_SCAN2)
                      || (state_reg == S_LIST);
    assign last_row = rvalid_reg && (raddr_d_reg + 1'b1 == count_reg);
    assign row_key  = rvalid_reg && !rrow.broken
                      && (rrow.key == req_reg.key_id[KEY_BITS-1:0]);
    assign row_match = rvalid_reg && (rrow.key == req_reg.key_id[KEY_BITS-1:0])
                      && (rrow.src == req_reg.source_id[SOURCE_BITS-1:0]);

    // add writes a new row; a broken report rewrites a matching row with its mark set
    always_comb
    begin
        we   = 1'b0;
        wrow = rrow;
        if (add_ok)
        begin
            we          = 1'b1;
            wrow.key    = req.key_id[KEY_BITS-1:0];
            wrow.src    = req.source_id[SOURCE_BITS-1:0];
            wrow.prio   = req.priority_req;
            wrow.wt     = req.weight;
            wrow.broken = 1'b0;
        end
        else if (state_reg == S_SCAN1 && action_t'(req_reg.action) == ACT_BROKEN
                 && row_match)
        begin
            we          = 1'b1;
            wrow.broken = 1'b1;
        end
    end

    function automatic rsp_t row_rsp(input logic [CNT_BITS-1:0] i, input row_t r);
        rsp_t o;
        o.status          = ST_OK;
        o.entry_index     = 5'(i);
        o.chosen_source   = 16'(r.src);
        o.chosen_priority = r.prio;
        o.chosen_weight   = r.wt;
        o.last            = 1'b1;
        return o;
    endfunction

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (action_t'(req.action) == ACT_ADD)   state_next = S_EMIT;
                    else if (count_reg == '0)               state_next = S_EMIT;
                    else if (action_t'(req.action) == ACT_LIST) state_next = S_LIST;
                    else                                    state_next = S_SCAN1;
                end
            end
            S_SCAN1:
            begin
                // a pick without candidates skips the second pass
                if (last_row)
                begin
                    state_next = (action_t'(req_reg.action) == ACT_PICK
                                  && (found_reg || row_key)) ? S_MUL : S_EMIT;
                end
            end
            S_MUL:   state_next = S_SCAN2;
            S_SCAN2:
            begin
                if (last_row || (rvalid_reg && done_reg)) state_next = S_EMIT;
            end
            S_LIST:
            begin
                if (last_row || (nout_reg == 6'(MAX_OUT))) state_next = S_EMIT;
            end
            S_EMIT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // scan address
    always_comb
    begin
        addr_next = addr_reg;
        if (state_reg == S_IDLE)
        begin
            addr_next = '0;
        end
        else if (state_reg == S_MUL)
        begin
            addr_next = CNT_BITS'(first_reg);
        end
        else if (scanning && addr_reg < count_reg)
        begin
            addr_next = addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            rvalid_reg <= 1'b0;
            done_reg   <= 1'b0;
            hold_v_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            rvalid_reg <= scanning && (addr_reg < count_reg) && (state_next == state_reg);
            raddr_d_reg <= addr_reg;
            if (add_ok)
            begin
                count_reg <= count_reg + 1'b1;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    hold_v_reg <= 1'b0;
                    if (start)
                    begin
                        req_reg   <= req;
                        found_reg <= 1'b0;
                        hit_reg   <= 1'b0;
                        sum_reg   <= '0;
                        psum_reg  <= '0;
                        nout_reg  <= '0;
                        if (action_t'(req.action) == ACT_ADD)
                        begin
                            if (add_ok)
                            begin
                                rsp_reg <= '{status: ST_OK,
                                             entry_index: 5'(count_reg),
                                             chosen_source: 16'(req.source_id[SOURCE_BITS-1:0]),
                                             chosen_priority: req.priority_req,
                                             chosen_weight: req.weight, last: 1'b1};
                            end
                            else
                            begin
                                rsp_reg <= '{status: ST_FULL, entry_index: 5'd0,
                                             chosen_source: 16'(req.source_id[SOURCE_BITS-1:0]),
                                             chosen_priority: req.priority_req,
                                             chosen_weight: req.weight, last: 1'b1};
                            end
                        end
                        else
                        begin
                            rsp_reg <= '{status: ST_NONE, default: '0, last: 1'b1};
                        end
                    end
                end
                S_SCAN1:
                begin
                    if (action_t'(req_reg.action) == ACT_BROKEN)
                    begin
                        if (row_match)
                        begin
                            hit_reg <= 1'b1;
                            rsp_reg.status <= ST_OK;
                        end
                    end
                    else if (row_key)
                    begin
                        // new top priority restarts the sum
                        if (!found_reg || rrow.prio > top_reg)
                        begin
                            found_reg <= 1'b1;
                            top_reg   <= rrow.prio;
                            first_reg <= raddr_d_reg[IDX_BITS-1:0];
                            rsp_reg   <= row_rsp(raddr_d_reg, rrow);
                            sum_reg   <= (rrow.wt > 0) ? SUM_BITS'(rrow.wt) : '0;
                        end
                        else if (rrow.prio == top_reg && rrow.wt > 0)
                        begin
                            sum_reg <= sum_reg + SUM_BITS'(rrow.wt);
                        end
                    end
                end
                S_MUL:
                begin
                    done_reg   <= 1'b0;
                    target_reg <= (SUM_BITS+16)'(req_reg.random_fraction) * sum_reg;
                end
                S_SCAN2:
                begin
                    if (row_key && rrow.prio == top_reg && rrow.wt > 0 && !done_reg)
                    begin
                        if (target_reg < {psum_reg + SUM_BITS'(rrow.wt), 16'd0})
                        begin
                            rsp_reg  <= row_rsp(raddr_d_reg, rrow);
                            done_reg <= 1'b1;
                        end
                        psum_reg <= psum_reg + SUM_BITS'(rrow.wt);
                    end
                    else
                    begin
                        done_reg <= done_reg;
                    end
                end
                S_LIST:
                begin
                    if (row_key && nout_reg < 6'(MAX_OUT))
                    begin
                        hold_reg   <= row_rsp(raddr_d_reg, rrow);
                        hold_v_reg <= 1'b1;
                        nout_reg   <= nout_reg + 1'b1;
                    end
                end
                S_EMIT:
                begin
                    hold_v_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // outputs: in list mode the held row goes out when the next match lands
    always_comb
    begin
        busy = (state_reg != S_IDLE);
        done = 1'b0;
        rsp  = rsp_reg;
        unique case (state_reg)
            S_EMIT:
            begin
                done = 1'b1;
                if (action_t'(req_reg.action) == ACT_LIST && hold_v_reg)
                begin
                    rsp = hold_reg;
                end
            end
            S_LIST:
            begin
                if (row_key && hold_v_reg && nout_reg < 6'(MAX_OUT))
                begin
                    done = 1'b1;
                    rsp  = hold_reg;
                    rsp.last = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ hw/rtl/pwrp_checker.sv @@
// ============================================================================
// pwrp_checker: port-level checks
// Watches handshake and result beats of the picker core.
// ============================================================================
module pwrp_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input pwrp_pkg::rsp_t rsp
);
    import pwrp_pkg::*;

    // an accepted item always raises busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("busy not raised");

    // the final beat of an item drops busy next
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.last |=> !busy) else $error("busy held after last beat");

    // no beat while idle
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("beat while idle");

    // a failed beat is always a lone last beat
    a_fail: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status != ST_OK |-> rsp.last) else $error("fail beat not last");

endmodule

bind priority_weighted_random_picker_core pwrp_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done), .rsp(rsp));

@@ test/priority_weighted_random_picker_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_weighted_random_picker_core_tb: self-checking testbench
// Drives add, report-broken, pick and list commands through the start/busy
// handshake, predicts every result beat from a local copy of the source table,
// and compares each strobed beat as a whole against the oldest prediction.
// ----------------------------------------------------------------------------
module priority_weighted_random_picker_core_tb;
    import pwrp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 200;
    localparam int RANDOM_ITEMS   = 126;

    logic clk;
    logic rst_n;
    logic start;
    req_t req;
    logic busy;
    logic done;
    rsp_t rsp;

    priority_weighted_random_picker_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    // Predicted table contents; only slots below tbl_count are ever read.
    logic [15:0]        tbl_key    [ENTRIES];
    logic [15:0]        tbl_src    [ENTRIES];
    logic signed [7:0]  tbl_prio   [ENTRIES];
    logic signed [15:0] tbl_wt     [ENTRIES];
    logic               tbl_broken [ENTRIES];
    int                 tbl_count = 0;

    req_t pending_cmds [$];
    rsp_t expected_beats [$];

    int   errors = 0;
    int   beats_seen = 0;
    int   cmds_sent = 0;
    int   idle_cycles;
    int   stall_left;
    bit   stall_enable;
    bit   hold_sender;
    bit   dataflow_done;
    // a command was taken at the last rising edge
    bit   in_taken;

    int   n_add = 0, n_broken = 0, n_pick = 0, n_list = 0;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic void queue_beat(rsp_t b);
        expected_beats.insert(expected_beats.size(), b);
    endfunction

    function automatic void queue_cmd(req_t c);
        pending_cmds.insert(pending_cmds.size(), c);
    endfunction

    function automatic rsp_t make_beat(logic [1:0] st, int slot, logic bit_last);
        rsp_t b;
        b = '0;
        b.status = st;
        if (slot >= 0)
        begin
            b.entry_index     = slot[4:0];
            b.chosen_source   = tbl_src[slot];
            b.chosen_priority = tbl_prio[slot];
            b.chosen_weight   = tbl_wt[slot];
        end
        b.last = bit_last;
        return b;
    endfunction

    // Work out the beats one accepted command causes and update the table.
    task automatic predict_command(input req_t c);
        int                 i;
        int                 k;
        int                 first;
        logic signed [7:0]  top;
        bit                 found;
        bit                 hit;
        longint unsigned    sum;
        longint unsigned    psum;
        longint unsigned    target;
        rsp_t               b;
        case (action_t'(c.action))
            ACT_ADD:
            begin
                n_add++;
                if (tbl_count >= ENTRIES)
                begin
                    b = '0;
                    b.status          = ST_FULL;
                    b.chosen_source   = c.source_id;
                    b.chosen_priority = c.priority_req;
                    b.chosen_weight   = c.weight;
                    b.last            = 1'b1;
                    queue_beat(b);
                end
                else
                begin
                    tbl_key[tbl_count]    = c.key_id;
                    tbl_src[tbl_count]    = c.source_id;
                    tbl_prio[tbl_count]   = c.priority_req;
                    tbl_wt[tbl_count]     = c.weight;
                    tbl_broken[tbl_count] = 1'b0;
                    queue_beat(make_beat(ST_OK, tbl_count, 1'b1));
                    tbl_count++;
                end
            end
            ACT_BROKEN:
            begin
                n_broken++;
                hit = 1'b0;
                for (i = 0; i < tbl_count; i++)
                    if (tbl_key[i] == c.key_id && tbl_src[i] == c.source_id)
                    begin
                        tbl_broken[i] = 1'b1;
                        hit = 1'b1;
                    end
                queue_beat(make_beat(hit ? ST_OK : ST_NONE, -1, 1'b1));
            end
            ACT_PICK:
            begin
                n_pick++;
                found = 1'b0;
                top   = '0;
                first = 0;
                sum   = 0;
                for (i = 0; i < tbl_count; i++)
                begin
                    if (tbl_broken[i] || tbl_key[i] != c.key_id)
                        continue;
                    if (!found || tbl_prio[i] > top)
                    begin
                        found = 1'b1;
                        top   = tbl_prio[i];
                        first = i;
                        sum   = 0;
                    end
                    else if (tbl_prio[i] < top)
                        continue;
                    if (tbl_wt[i] > 0)
                        sum += longint'(tbl_wt[i]);
                end
                if (!found)
                    queue_beat(make_beat(ST_NONE, -1, 1'b1));
                else
                begin
                    target = longint'(c.random_fraction) * sum;
                    psum   = 0;
                    k      = first;
                    for (i = first; i < tbl_count; i++)
                    begin
                        if (tbl_broken[i] || tbl_key[i] != c.key_id || tbl_prio[i] != top)
                            continue;
                        if (tbl_wt[i] <= 0)
                            continue;
                        psum += longint'(tbl_wt[i]);
                        if (target < (psum << 16))
                        begin
                            k = i;
                            break;
                        end
                    end
                    queue_beat(make_beat(ST_OK, k, 1'b1));
                end
            end
            default:
            begin
                n_list++;
                k = 0;
                for (i = 0; i < tbl_count && k < MAX_OUT; i++)
                begin
                    if (tbl_broken[i] || tbl_key[i] != c.key_id)
                        continue;
                    queue_beat(make_beat(ST_OK, i, 1'b0));
                    k++;
                end
                if (k == 0)
                    queue_beat(make_beat(ST_NONE, -1, 1'b1));
                else
                    expected_beats[$].last = 1'b1;
            end
        endcase
    endtask

    function automatic req_t build_cmd(action_t a, logic [15:0] key, logic [15:0] src,
                                       logic [7:0] prio, logic [15:0] wt,
                                       logic [15:0] frac);
        req_t c;
        c.action          = a;
        c.key_id          = key;
        c.source_id       = src;
        c.priority_req    = prio;
        c.weight          = wt;
        c.random_fraction = frac;
        return c;
    endfunction

    // Keys come from a tiny pool so that picks and lists find real candidates;
    // a rare wide key exercises every key bit.
    function automatic logic [15:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom);
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic req_t random_cmd(int phase);
        logic [15:0] key;
        logic [15:0] src;
        logic [7:0]  prio;
        logic [15:0] wt;
        action_t     a;
        int          roll;
        key  = pick_key();
        src  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
        prio = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
        wt   = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024));
        roll = $urandom_range(0, 99);
        // Fill phase favors adds; later phases favor picks and lists.
        if (phase == 0)
            a = (roll < 60) ? ACT_ADD : (roll < 70) ? ACT_BROKEN
                : (roll < 88) ? ACT_PICK : ACT_LIST;
        else
            a = (roll < 15) ? ACT_ADD : (roll < 30) ? ACT_BROKEN
                : (roll < 70) ? ACT_PICK : ACT_LIST;
        return build_cmd(a, key, src, prio, wt, 16'($urandom));
    endfunction

    // Driver: present the head of the queue, hold it until accepted, idle at random.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            req        <= '0;
            stall_left <= 0;
        end
        else if (in_taken)
        begin
            // accepted at the previous rising edge; advance
            if (stall_enable && $urandom_range(0, 3) == 0)
            begin
                start      <= 1'b0;
                stall_left <= $urandom_range(1, 18);
            end
            else if (pending_cmds.size() > 0 && !hold_sender)
            begin
                req   <= pending_cmds.pop_front();
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
        else if (!start)
        begin
            if (stall_left > 0)
                stall_left <= stall_left - 1;
            else if (pending_cmds.size() > 0 && !hold_sender)
            begin
                req   <= pending_cmds.pop_front();
                start <= 1'b1;
            end
        end
    end

    // Monitor: record accepted commands and check each strobed beat.
    always @(posedge clk)
    begin
        in_taken <= rst_n && start && !busy;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predict_command(req);
                cmds_sent++;
            end
            if (done)
            begin
                beats_seen++;
                if (expected_beats.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected beat, expected none, actual %p", $time, rsp);
                end
                else
                begin
                    rsp_t e;
                    e = expected_beats.pop_front();
                    if (rsp !== e)
                    begin
                        errors++;
                        $display("%0t: beat mismatch, expected %p, actual %p",
                                 $time, e, rsp);
                    end
                end
            end
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
        else
            idle_cycles <= 0;
    end

    // Watchdog: a long stretch with no accepted beat on either side ends the run.
    always @(posedge clk)
    begin
        if (!dataflow_done && idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: timeout, %0d beats still expected", $time,
                     expected_beats.size());
            $display("priority_weighted_random_picker_core_tb failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || start || busy || expected_beats.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        int i;
        stall_enable = 1'b0; hold_sender = 1'b0; dataflow_done = 1'b0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty table, field extremes, priority tiers, zero and
        // negative weights, broken marks with and without a match.
        queue_cmd(build_cmd(ACT_PICK,   16'h0001, 0, 0, 0, 16'h0000));
        queue_cmd(build_cmd(ACT_LIST,   16'h0001, 0, 0, 0, 0));
        queue_cmd(build_cmd(ACT_BROKEN, 16'h0001, 16'h0001, 0, 0, 0));
        queue_cmd(build_cmd(ACT_ADD, 16'h0001, 16'h0010, 8'h7F, 16'h0000, 0));
        queue_cmd(build_cmd(ACT_ADD, 16'h0001, 16'h0011, 8'h7F, 16'h8000, 0));
        queue_cmd(build_cmd(ACT_PICK,   16'h0001, 0, 0, 0, 16'hFFFF));
        queue_cmd(build_cmd(ACT_ADD, 16'h0001, 16'h0012, 8'h7F, 16'h7FFF, 0));
        queue_cmd(build_cmd(ACT_ADD, 16'h0001, 16'h0013, 8'h7F, 16'h0100, 0));
        queue_cmd(build_cmd(ACT_ADD, 16'h0001, 16'h0014, 8'h80, 16'h0200, 0));
        queue_cmd(build_cmd(ACT_PICK,   16'h0001, 0, 0, 0, 16'h0000));
        queue_cmd(build_cmd(ACT_PICK,   16'h0001, 0, 0, 0, 16'hFFFF));
        queue_cmd(build_cmd(ACT_ADD, 16'hFFFF, 16'hFFFF, 8'h80, 16'hFFFF, 0));
        queue_cmd(build_cmd(ACT_ADD, 16'h0000, 16'h0000, 8'h00, 16'h0001, 0));
        queue_cmd(build_cmd(ACT_LIST,   16'h0001, 0, 0, 0, 0));
        queue_cmd(build_cmd(ACT_BROKEN, 16'h0001, 16'h0012, 0, 0, 0));
        queue_cmd(build_cmd(ACT_PICK,   16'h0001, 0, 0, 0, 16'h8000));
        queue_cmd(build_cmd(ACT_BROKEN, 16'hFFFF, 16'hFFFF, 0, 0, 0));
        queue_cmd(build_cmd(ACT_PICK,   16'hFFFF, 0, 0, 0, 16'h1234));
        queue_cmd(build_cmd(ACT_LIST,   16'hFFFF, 0, 0, 0, 0));
        // Fill the table to the brim with one key, then overflow and list it.
        for (i = 0; i < 25; i++)
            queue_cmd(build_cmd(ACT_ADD, 16'h0002, 16'(i), 8'h01,
                                16'(i * 37), 0));
        queue_cmd(build_cmd(ACT_ADD, 16'hABCD, 16'hFFFF, 8'h80, 16'h8000, 0));
        queue_cmd(build_cmd(ACT_ADD, 16'h0000, 16'h0000, 8'h7F, 16'h7FFF, 0));
        queue_cmd(build_cmd(ACT_LIST,   16'h0002, 0, 0, 0, 0));
        queue_cmd(build_cmd(ACT_PICK,   16'h0002, 0, 0, 0, 16'($urandom)));
        wait_drained();

        // Hold the sender once the queue is drained; reset is the only way to empty
        // the table, so the random part works a full table.
        hold_sender = 1'b1;
        repeat (4) @(posedge clk);
        hold_sender = 1'b0;

        // Random part with bursty idling; the last stretch runs flat out.
        stall_enable = 1'b1;
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            queue_cmd(random_cmd(i < 40 ? 0 : 1));
            if (i == RANDOM_ITEMS / 2)
            begin
                wait_drained();
            end
        end
        while (pending_cmds.size() > 40)
            @(posedge clk);
        stall_enable = 1'b0;
        wait_drained();
        dataflow_done = 1'b1;
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d commands (%0d add, %0d broken, %0d pick, %0d list), %0d beats.",
                 cmds_sent, n_add, n_broken, n_pick, n_list, beats_seen);
        $display("Table filled to %0d entries including overflow adds.", tbl_count);
        if (errors == 0 && expected_beats.size() == 0)
            $display("priority_weighted_random_picker_core_tb passed");
        else
            $display("priority_weighted_random_picker_core_tb failed");
        $finish;
    end

endmodule
